[sv/wfce_pkg.sv]
// shared types, constants and report codes of the wheel force-feedback command encoder
package wfce_pkg;

   // request kinds
   localparam logic [2:0] KIND_MODE   = 3'd0;
   localparam logic [2:0] KIND_RANGE  = 3'd1;
   localparam logic [2:0] KIND_CENTRE = 3'd2;
   localparam logic [2:0] KIND_FORCE  = 3'd3;
   localparam logic [2:0] KIND_STOP   = 3'd4;

   // port widths
   localparam int REQ_DATA_W = 16;
   localparam int REQ_USER_W = 3;
   localparam int RSP_DATA_W = 56;

   // clamp limits
   localparam logic signed [11:0] RANGE_MIN = 12'sd40;
   localparam logic signed [11:0] RANGE_MAX = 12'sd900;
   localparam logic signed [11:0] PCT_MAX   = 12'sd100;
   localparam logic signed [11:0] PCT_MIN   = -12'sd100;
   localparam logic [6:0]         PCT_FULL  = 7'd100;

   // scaling: x / 100 == (x * RECIP_100) >> RECIP_100_SHIFT for x below 2^23
   localparam logic [15:0] FULL_SCALE       = 16'hffff;
   localparam logic [14:0] FORCE_SCALE      = 15'h7fff;
   localparam logic [23:0] RECIP_100        = 24'd10737419;
   localparam int          RECIP_100_SHIFT  = 30;

   // spring expansion, knee at SPLIT_POINT
   localparam logic [15:0] SPLIT_POINT  = 16'haaaa;
   localparam logic [19:0] A_LOW_GAIN   = 20'h0c;
   localparam logic [19:0] A_HIGH_GAIN  = 20'h06;
   localparam logic [23:0] B_LOW_GAIN   = 24'h80;
   localparam logic [23:0] B_HIGH_GAIN  = 24'hff;
   localparam logic [19:0] A_KNEE       = 20'd524280;   // 0x0c * 0xaaaa
   localparam logic [23:0] B_KNEE       = 24'd5592320;  // 0x80 * 0xaaaa
   // x / 0xaaaa == (x * RECIP_SPLIT) >> RECIP_SPLIT_SHIFT for x below 2^24
   localparam logic [24:0] RECIP_SPLIT       = 25'd25166209;
   localparam int          RECIP_SPLIT_SHIFT = 40;

   localparam logic [15:0] FORCE_BIAS = 16'h8000;

   // report bytes
   localparam logic [7:0] OP_EXT         = 8'hf8;
   localparam logic [7:0] SUB_MODE_FIRST = 8'h0a;
   localparam logic [7:0] SUB_MODE_NEXT  = 8'h09;
   localparam logic [7:0] MODE_ARG_A     = 8'h05;
   localparam logic [7:0] MODE_ARG_B     = 8'h01;
   localparam logic [7:0] SUB_RANGE      = 8'h81;
   localparam logic [7:0] OP_CENTRE_OFF  = 8'hf5;
   localparam logic [7:0] OP_CENTRE_SET  = 8'hfe;
   localparam logic [7:0] SUB_CENTRE     = 8'h0d;
   localparam logic [7:0] OP_CENTRE_ON   = 8'h14;
   localparam logic [7:0] OP_FORCE       = 8'h11;
   localparam logic [7:0] OP_STOP        = 8'h13;

   // one report, byte 0 in the lowest bits
   typedef logic [6:0][7:0] report_type;

   // decoded and clamped request
   typedef struct packed {
      logic [2:0] kind;
      logic [9:0] degrees;
      logic       centre_off;
      logic [6:0] centre_pct;
      logic       force_neg;
      logic [6:0] force_pct;
   } dec_type;

   // item as it moves down the arithmetic pipeline
   typedef struct packed {
      dec_type     dec;
      logic [22:0] num_m;
      logic [21:0] num_f;
      logic [15:0] m;
      logic [14:0] mag_f;
      logic [18:0] a;
      logic [23:0] b;
      logic [7:0]  force_byte;
      logic [7:0]  qa;
      logic [7:0]  qb;
   } work_type;

endpackage

[sv/wfce_decode.sv]
// input stage: request decode and clamping of the amount
module wfce_decode (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_tvalid,
   output logic                                req_tready,
   input  logic [wfce_pkg::REQ_DATA_W-1:0]     req_tdata,  // [11:0] amount
   input  logic [wfce_pkg::REQ_USER_W-1:0]     req_tuser,  // [2:0] req_type
   output logic                                dec_valid,
   output wfce_pkg::dec_type                   dec_data,
   input  logic                                dec_ready
);
   import wfce_pkg::*;

   logic signed [11:0] amount;
   logic signed [11:0] neg_amount;
   logic               kind_ok;
   dec_type            dec_in;
   dec_type            dec_ff;
   logic               valid_ff;

   assign amount     = $signed(req_tdata[11:0]);
   assign neg_amount = -amount;
   assign kind_ok    = (req_tuser <= KIND_STOP);

   // clamp the amount for each kind
   always_comb begin
      dec_in      = '0;
      dec_in.kind = req_tuser;
      priority if (amount < RANGE_MIN) begin
         dec_in.degrees = RANGE_MIN[9:0];
      end else if (amount > RANGE_MAX) begin
         dec_in.degrees = RANGE_MAX[9:0];
      end else begin
         dec_in.degrees = amount[9:0];
      end
      dec_in.centre_off = (amount <= 12'sd0);
      dec_in.centre_pct = (amount > PCT_MAX) ? PCT_FULL : amount[6:0];
      dec_in.force_neg  = amount[11];
      priority if ((amount > PCT_MAX) || (amount < PCT_MIN)) begin
         dec_in.force_pct = PCT_FULL;
      end else if (amount[11]) begin
         dec_in.force_pct = neg_amount[6:0];
      end else begin
         dec_in.force_pct = amount[6:0];
      end
   end

   assign req_tready = !valid_ff || dec_ready;

   // undefined kinds are taken and dropped here
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (req_tready) begin
         valid_ff <= req_tvalid && kind_ok;
      end
   end

   always_ff @(posedge clock) begin
      if (req_tready) begin
         dec_ff <= dec_in;
      end
   end

   assign dec_valid = valid_ff;
   assign dec_data  = dec_ff;

endmodule

[sv/wfce_arith.sv]
// four-stage arithmetic pipeline: percent scaling, divide by 100, spring expansion and force bias, divide by knee
module wfce_arith (
   input  logic                clock,
   input  logic                reset,
   input  logic                dec_valid,
   input  wfce_pkg::dec_type   dec_data,
   output logic                dec_ready,
   output logic                work_valid,
   output wfce_pkg::work_type  work_data,
   input  logic                work_ready
);
   import wfce_pkg::*;

   localparam int NUM_STAGES = 4;

   work_type    stage_ff    [NUM_STAGES];
   work_type    stage_in    [NUM_STAGES];
   logic        valid_ff    [NUM_STAGES];
   logic        stage_ready [NUM_STAGES];

   logic [46:0] prod_m;
   logic [45:0] prod_f;
   logic [15:0] excess;
   logic [19:0] a_full;
   logic [15:0] biased;
   logic [43:0] prod_a;
   logic [48:0] prod_b;

   always_comb begin
      // stage 0: scale percent to full range numerators
      stage_in[0]       = '0;
      stage_in[0].dec   = dec_data;
      stage_in[0].num_m = 23'(FULL_SCALE) * 23'(dec_data.centre_pct);
      stage_in[0].num_f = 22'(FORCE_SCALE) * 22'(dec_data.force_pct);

      // stage 1: divide by 100 through the reciprocal
      prod_m          = 47'(stage_ff[0].num_m) * 47'(RECIP_100);
      prod_f          = 46'(stage_ff[0].num_f) * 46'(RECIP_100);
      stage_in[1]       = stage_ff[0];
      stage_in[1].m     = prod_m[RECIP_100_SHIFT +: 16];
      stage_in[1].mag_f = prod_f[RECIP_100_SHIFT +: 15];

      // stage 2: piecewise spring expansion and force bias
      stage_in[2] = stage_ff[1];
      excess      = stage_ff[1].m - SPLIT_POINT;
      if (stage_ff[1].m <= SPLIT_POINT) begin
         a_full        = 20'(stage_ff[1].m) * A_LOW_GAIN;
         stage_in[2].b = 24'(stage_ff[1].m) * B_LOW_GAIN;
      end else begin
         a_full        = A_KNEE + 20'(excess) * A_HIGH_GAIN;
         stage_in[2].b = B_KNEE + 24'(excess) * B_HIGH_GAIN;
      end
      stage_in[2].a = a_full[19:1];
      biased = stage_ff[1].dec.force_neg ? (FORCE_BIAS - 16'(stage_ff[1].mag_f))
                                         : (FORCE_BIAS + 16'(stage_ff[1].mag_f));
      stage_in[2].force_byte = biased[15:8];

      // stage 3: divide by the knee through the reciprocal
      prod_a         = 44'(stage_ff[2].a) * 44'(RECIP_SPLIT);
      prod_b         = 49'(stage_ff[2].b) * 49'(RECIP_SPLIT);
      stage_in[3]    = stage_ff[2];
      stage_in[3].qa = 8'(prod_a >> RECIP_SPLIT_SHIFT);
      stage_in[3].qb = 8'(prod_b >> RECIP_SPLIT_SHIFT);
   end

   // a stage loads when it is empty or its item moves on
   always_comb begin
      stage_ready[NUM_STAGES-1] = !valid_ff[NUM_STAGES-1] || work_ready;
      for (int k = NUM_STAGES - 2; k >= 0; k--) begin
         stage_ready[k] = !valid_ff[k] || stage_ready[k+1];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int k = 0; k < NUM_STAGES; k++) begin
            valid_ff[k] <= 1'b0;
         end
      end else begin
         if (stage_ready[0]) begin
            valid_ff[0] <= dec_valid;
         end
         for (int k = 1; k < NUM_STAGES; k++) begin
            if (stage_ready[k]) begin
               valid_ff[k] <= valid_ff[k-1];
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      for (int k = 0; k < NUM_STAGES; k++) begin
         if (stage_ready[k]) begin
            stage_ff[k] <= stage_in[k];
         end
      end
   end

   assign dec_ready  = stage_ready[0];
   assign work_valid = valid_ff[NUM_STAGES-1];
   assign work_data  = stage_ff[NUM_STAGES-1];

   // a stalled final stage keeps its item
   a_tail_holds: assert property (@(posedge clock) disable iff (reset)
      (valid_ff[NUM_STAGES-1] && !work_ready) |=>
      (valid_ff[NUM_STAGES-1] && $stable(stage_ff[NUM_STAGES-1])))
      else $error("arith tail item lost or changed under stall");

endmodule

[sv/wfce_out.sv]
// output stage: report assembly and one-or-two report sequencer
module wfce_out (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                work_valid,
   input  wfce_pkg::work_type                  work_data,
   output logic                                work_ready,
   output logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   output logic [wfce_pkg::RSP_DATA_W-1:0]     rsp_tdata,
   output logic                                rsp_tlast
);
   import wfce_pkg::*;

   report_type rpt_in [2];
   report_type rpt_ff [2];
   logic       two_in;
   logic       two_ff;
   logic       hold_valid_ff;
   logic       sel_ff;
   logic       take;
   logic       last_take;

   // build the reports of one request
   always_comb begin
      rpt_in[0] = '0;
      rpt_in[1] = '0;
      two_in    = 1'b0;
      unique case (work_data.dec.kind)
         KIND_MODE: begin
            rpt_in[0][0] = OP_EXT;
            rpt_in[0][1] = SUB_MODE_FIRST;
            rpt_in[1][0] = OP_EXT;
            rpt_in[1][1] = SUB_MODE_NEXT;
            rpt_in[1][2] = MODE_ARG_A;
            rpt_in[1][3] = MODE_ARG_B;
            rpt_in[1][4] = MODE_ARG_B;
            two_in       = 1'b1;
         end
         KIND_RANGE: begin
            rpt_in[0][0] = OP_EXT;
            rpt_in[0][1] = SUB_RANGE;
            rpt_in[0][2] = work_data.dec.degrees[7:0];
            rpt_in[0][3] = {6'b0, work_data.dec.degrees[9:8]};
         end
         KIND_CENTRE: begin
            if (work_data.dec.centre_off) begin
               rpt_in[0][0] = OP_CENTRE_OFF;
            end else begin
               rpt_in[0][0] = OP_CENTRE_SET;
               rpt_in[0][1] = SUB_CENTRE;
               rpt_in[0][2] = work_data.qa;
               rpt_in[0][3] = work_data.qa;
               rpt_in[0][4] = work_data.qb;
               rpt_in[1][0] = OP_CENTRE_ON;
               two_in       = 1'b1;
            end
         end
         KIND_FORCE: begin
            rpt_in[0][0] = OP_FORCE;
            rpt_in[0][2] = work_data.force_byte;
         end
         KIND_STOP: begin
            rpt_in[0][0] = OP_STOP;
            rpt_in[1][0] = OP_CENTRE_OFF;
            two_in       = 1'b1;
         end
         default: begin
            two_in = 1'b0;
         end
      endcase
   end

   assign take       = rsp_tvalid && rsp_tready;
   assign last_take  = take && rsp_tlast;
   assign work_ready = !hold_valid_ff || last_take;

   // hold register and report select
   always_ff @(posedge clock) begin
      if (reset) begin
         hold_valid_ff <= 1'b0;
         sel_ff        <= 1'b0;
      end else begin
         if (work_ready) begin
            hold_valid_ff <= work_valid;
            sel_ff        <= 1'b0;
         end else if (take) begin
            sel_ff <= 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (work_ready && work_valid) begin
         rpt_ff[0] <= rpt_in[0];
         rpt_ff[1] <= rpt_in[1];
         two_ff    <= two_in;
      end
   end

   assign rsp_tvalid = hold_valid_ff;
   assign rsp_tdata  = sel_ff ? rpt_ff[1] : rpt_ff[0];
   assign rsp_tlast  = !two_ff || sel_ff;

   // the second report follows the first one at once
   a_second_follows: assert property (@(posedge clock) disable iff (reset)
      (take && !rsp_tlast) |=> (rsp_tvalid && rsp_tlast))
      else $error("second report missing after first");

   // second report selected only for a held two-report item
   a_sel_valid: assert property (@(posedge clock) disable iff (reset)
      sel_ff |-> (hold_valid_ff && two_ff))
      else $error("second report selected without a two-report item");

   // a newly loaded item starts on its first report
   a_load_first: assert property (@(posedge clock) disable iff (reset)
      (work_valid && work_ready) |=> (rsp_tvalid && !sel_ff))
      else $error("loaded item does not start with first report");

endmodule

[sv/wheel_ffb_command_encoder.sv]
// top level of the wheel force-feedback command encoder
//
//   channel | dir | ports                               | item
//   req     | in  | req_tvalid/tready/tdata/tuser       | request kind and signed amount
//   rsp     | out | rsp_tvalid/tready/tdata/tlast       | one 7-byte report, tlast on final one
//
// the encoder gives one report per cycle while rsp_tready is high: range, force
// and autocentre off cause one report each, mode switch, autocentre on and stop
// cause two, which the output sequencer sends in order. the first report passes
// the decode register, four arithmetic stages and the output register before it
// is offered. reset clears all valid bits. a stall on rsp holds every full stage;
// items of defined kinds are never dropped or repeated.
module wheel_ffb_command_encoder (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_tvalid,
   output logic                                req_tready,
   input  logic [wfce_pkg::REQ_DATA_W-1:0]     req_tdata,  // [11:0] amount, [15:12] zero
   input  logic [wfce_pkg::REQ_USER_W-1:0]     req_tuser,  // [2:0] req_type
   output logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   output logic [wfce_pkg::RSP_DATA_W-1:0]     rsp_tdata,  // byte0 [7:0] .. byte6 [55:48]
   output logic                                rsp_tlast
);
   import wfce_pkg::*;

   logic     dec_valid;
   logic     dec_ready;
   dec_type  dec_data;
   logic     work_valid;
   logic     work_ready;
   work_type work_data;

   // decode and clamp
   wfce_decode u_decode (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .dec_valid  (dec_valid),
      .dec_data   (dec_data),
      .dec_ready  (dec_ready)
   );

   // scaling and spring arithmetic
   wfce_arith u_arith (
      .clock      (clock),
      .reset      (reset),
      .dec_valid  (dec_valid),
      .dec_data   (dec_data),
      .dec_ready  (dec_ready),
      .work_valid (work_valid),
      .work_data  (work_data),
      .work_ready (work_ready)
   );

   // report assembly and sequencing
   wfce_out u_out (
      .clock      (clock),
      .reset      (reset),
      .work_valid (work_valid),
      .work_data  (work_data),
      .work_ready (work_ready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast)
   );

endmodule

[test/tb_wheel_ffb_command_encoder.sv]
// self-checking testbench for the wheel force-feedback command encoder
module tb_wheel_ffb_command_encoder;
   import wfce_pkg::*;

   localparam int CYCLE_LIMIT   = 200000;
   localparam int SETTLE_CYCLES = 16;     // a little over the report latency
   localparam int HOLDOFF_LEN   = 400;
   localparam int IDLE_PCT      = 14;
   localparam int MAX_SHOWN     = 10;

   // one expected report and its tlast flag
   typedef struct {
      report_type bytes;
      logic       last;
   } report_item_type;

   logic                  clock      = 1'b0;
   logic                  reset      = 1'b1;
   logic                  req_tvalid = 1'b0;
   logic                  req_tready;
   logic [REQ_DATA_W-1:0] req_tdata  = '0;   // [11:0] amount, [15:12] zero
   logic [REQ_USER_W-1:0] req_tuser  = '0;   // [2:0] req_type
   logic                  rsp_tvalid;
   logic                  rsp_tready = 1'b0;
   logic [RSP_DATA_W-1:0] rsp_tdata;         // byte0 [7:0] .. byte6 [55:48]
   logic                  rsp_tlast;

   report_item_type pending_reports[$];
   int         error_count     = 0;
   int         cycle_count     = 0;
   int         holdoff_request = 0;
   bit         no_idle         = 1'b0;

   wheel_ffb_command_encoder u_top (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast)
   );

   // clock
   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // run limit
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("wheel_ffb_command_encoder test failed");
         $finish;
      end
   end

   // reports that one request causes; returns how many
   function automatic int encode_request(input logic [2:0] kind, input logic [11:0] raw,
                                         output report_type first, output report_type second);
      int amt;
      int deg;
      int pct;
      int mag;
      int a;
      int b;
      int level;
      int fbyte;
      amt    = $signed(raw);
      first  = '0;
      second = '0;
      case (kind)
         KIND_MODE: begin
            first[0]  = OP_EXT;
            first[1]  = SUB_MODE_FIRST;
            second[0] = OP_EXT;
            second[1] = SUB_MODE_NEXT;
            second[2] = MODE_ARG_A;
            second[3] = MODE_ARG_B;
            second[4] = MODE_ARG_B;
            return 2;
         end
         KIND_RANGE: begin
            deg = (amt < 40) ? 40 : ((amt > 900) ? 900 : amt);
            first[0] = OP_EXT;
            first[1] = SUB_RANGE;
            first[2] = deg[7:0];
            first[3] = deg[15:8];
            return 1;
         end
         KIND_CENTRE: begin
            if (amt <= 0) begin
               first[0] = OP_CENTRE_OFF;
               return 1;
            end
            pct = (amt > 100) ? 100 : amt;
            mag = (65535 * pct) / 100;
            // spring expansion bends at the knee
            if (mag <= int'(SPLIT_POINT)) begin
               a = 'h0c * mag;
               b = 'h80 * mag;
            end else begin
               a = 'h0c * int'(SPLIT_POINT) + 'h06 * (mag - int'(SPLIT_POINT));
               b = 'h80 * int'(SPLIT_POINT) + 'hff * (mag - int'(SPLIT_POINT));
            end
            a = a >> 1;
            a = a / int'(SPLIT_POINT);
            b = b / int'(SPLIT_POINT);
            first[0]  = OP_CENTRE_SET;
            first[1]  = SUB_CENTRE;
            first[2]  = a[7:0];
            first[3]  = a[7:0];
            first[4]  = b[7:0];
            second[0] = OP_CENTRE_ON;
            return 2;
         end
         KIND_FORCE: begin
            pct   = (amt < -100) ? -100 : ((amt > 100) ? 100 : amt);
            level = (32767 * pct) / 100;
            fbyte = ((level + 'h8000) >> 8) & 'hff;
            first[0] = OP_FORCE;
            first[2] = fbyte[7:0];
            return 1;
         end
         KIND_STOP: begin
            first[0]  = OP_STOP;
            second[0] = OP_CENTRE_OFF;
            return 2;
         end
         default: return 0;
      endcase
   endfunction

   task automatic flag_error(input string msg);
      error_count++;
      if (error_count <= MAX_SHOWN)
         $display("error at cycle %0d: %s", cycle_count, msg);
   endtask

   // offer one request until taken, queue its reports, maybe idle afterwards
   task automatic send_request(input logic [2:0] kind, input logic [11:0] amount);
      bit         taken;
      int         count;
      report_type first;
      report_type second;
      req_tuser  <= kind;
      req_tdata  <= {4'b0, amount};
      req_tvalid <= 1'b1;
      taken = 1'b0;
      while (!taken) begin
         @(negedge clock);
         taken = req_tready;
         if (taken) begin
            count = encode_request(kind, amount, first, second);
            if (count > 0)
               pending_reports.push_back('{bytes: first, last: (count == 1)});
            if (count > 1)
               pending_reports.push_back('{bytes: second, last: 1'b1});
         end
         @(posedge clock);
      end
      if (!no_idle && $urandom_range(99) < IDLE_PCT) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
   endtask

   task automatic stop_offering();
      req_tvalid <= 1'b0;
      @(posedge clock);
   endtask

   task automatic wait_drained();
      while (pending_reports.size() != 0) @(posedge clock);
   endtask

   // amount biased toward the clamp edges of each kind
   function automatic logic [11:0] pick_amount(input logic [2:0] kind);
      int v;
      if ($urandom_range(99) < 30)
         v = $urandom_range(0, 4095);
      else if (kind == KIND_RANGE)
         v = $urandom_range(0, 960);
      else
         v = int'($urandom_range(0, 240)) - 120;
      return v[11:0];
   endfunction

   function automatic logic [2:0] pick_kind();
      if ($urandom_range(99) < 8)
         return 3'($urandom_range(5, 7));
      return 3'($urandom_range(KIND_MODE, KIND_STOP));
   endfunction

   // random stream; undefined kinds cause nothing and are not counted
   task automatic send_random(input int wanted);
      int         sent;
      logic [2:0] kind;
      sent = 0;
      while (sent < wanted) begin
         kind = pick_kind();
         send_request(kind, pick_amount(kind));
         if (kind <= KIND_STOP)
            sent++;
      end
   endtask

   // receiver: random stalls, steady stretches and long hold-offs
   initial begin : receiver
      int holdoff_left;
      int holdoff_seen;
      holdoff_left = 0;
      holdoff_seen = 0;
      forever begin
         @(posedge clock);
         if (holdoff_request != holdoff_seen) begin
            holdoff_seen = holdoff_request;
            holdoff_left = HOLDOFF_LEN;
         end
         if (holdoff_left > 0) begin
            holdoff_left--;
            rsp_tready <= 1'b0;
         end else if (no_idle)
            rsp_tready <= 1'b1;
         else
            rsp_tready <= ($urandom_range(99) >= IDLE_PCT);
      end
   end

   // compare each accepted report with the oldest one queued
   always @(negedge clock) begin
      report_item_type want;
      report_type got;
      if (!reset && rsp_tvalid && rsp_tready) begin
         got = rsp_tdata;
         if (pending_reports.size() == 0)
            flag_error($sformatf("unexpected report %h last %b", rsp_tdata, rsp_tlast));
         else begin
            want = pending_reports.pop_front();
            for (int j = 0; j < 7; j++)
               if (got[j] !== want.bytes[j])
                  flag_error($sformatf("byte%0d expected %h actual %h",
                                       j, want.bytes[j], got[j]));
            if (rsp_tlast !== want.last)
               flag_error($sformatf("last expected %b actual %b", want.last, rsp_tlast));
         end
      end
   end

   // fixed reports and the undefined kinds
   task automatic test_mode_and_stop();
      send_request(KIND_MODE, 12'h000);
      send_request(KIND_STOP, 12'hfff);
      send_request(3'd5, 12'h7ff);
      send_request(3'd6, 12'h800);
      send_request(3'd7, 12'h555);
      stop_offering();
   endtask

   // degrees below, at and above both limits
   task automatic test_range_clamp();
      send_request(KIND_RANGE, 12'h800);
      send_request(KIND_RANGE, 12'd39);
      send_request(KIND_RANGE, 12'd40);
      send_request(KIND_RANGE, 12'd900);
      send_request(KIND_RANGE, 12'd901);
      send_request(KIND_RANGE, 12'h7ff);
      stop_offering();
   endtask

   // spring off, smallest on, either side of the knee, full and clamped
   task automatic test_centre_spring();
      send_request(KIND_CENTRE, 12'h800);
      send_request(KIND_CENTRE, 12'd0);
      send_request(KIND_CENTRE, 12'd1);
      send_request(KIND_CENTRE, 12'd66);
      send_request(KIND_CENTRE, 12'd67);
      send_request(KIND_CENTRE, 12'd100);
      send_request(KIND_CENTRE, 12'h7ff);
      stop_offering();
   endtask

   // force clamps and truncation toward zero near zero
   task automatic test_force_level();
      send_request(KIND_FORCE, 12'h800);
      send_request(KIND_FORCE, -12'sd100);
      send_request(KIND_FORCE, 12'hfff);
      send_request(KIND_FORCE, 12'd0);
      send_request(KIND_FORCE, 12'd1);
      send_request(KIND_FORCE, 12'd100);
      send_request(KIND_FORCE, 12'h7ff);
      stop_offering();
   endtask

   // random items with a pause in the middle until all reports are back
   task automatic test_random_stream();
      send_random(190);
      stop_offering();
      wait_drained();
      send_random(190);
      stop_offering();
   endtask

   // back-to-back items with neither side idling
   task automatic test_steady_stream();
      no_idle = 1'b1;
      send_random(100);
      stop_offering();
      no_idle = 1'b0;
   endtask

   // receiver holds off while the sender keeps offering, filling the pipeline
   task automatic test_output_stall();
      holdoff_request++;
      send_random(60);
      stop_offering();
      wait_drained();
   endtask

   initial begin
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_mode_and_stop();
      test_range_clamp();
      test_centre_spring();
      test_force_level();
      test_random_stream();
      test_steady_stream();
      test_output_stall();
      wait_drained();
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (error_count == 0 && pending_reports.size() == 0)
         $display("wheel_ffb_command_encoder test passed");
      else
         $display("wheel_ffb_command_encoder test failed");
      $finish;
   end

endmodule
